// File: rtl/bii_pkg.sv
package bii_pkg;

    // Sizing of the index
    localparam int NUM_NODES      = 256;
    localparam int SLOTS_PER_NODE = 16;
    localparam int STORE_DEPTH    = NUM_NODES * SLOTS_PER_NODE;

    // Fixed field widths of the words
    localparam int OP_W     = 1;
    localparam int ROW_W    = 15;
    localparam int NODE_W   = 8;
    localparam int SLOTF_W  = 4;
    localparam int PLACED_W = 5;
    localparam int VALUE_W  = 16;

    // Derived internal widths
    localparam int NODE_IDX_W = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int CNT_W      = $clog2(SLOTS_PER_NODE + 1);
    localparam int ADDR_W     = $clog2(STORE_DEPTH);

    localparam int NUM_COLS = 4;
    localparam int COL_W    = 2;

    localparam logic [OP_W-1:0]    OP_INSERT  = 1'b0;
    localparam logic [OP_W-1:0]    OP_READ    = 1'b1;
    localparam logic [VALUE_W-1:0] FREE_VALUE = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             load;
        logic             lookup;
        logic             update;
        logic             emit;
        logic [COL_W-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic is_read;
        logic out_free;
    } t_status;

endpackage

// File: rtl/bii_if.sv
interface bii_in_if;
    logic                         valid;
    logic                         ready;
    logic [bii_pkg::OP_W-1:0]     op;
    logic [bii_pkg::ROW_W-1:0]    row;
    logic [bii_pkg::NODE_W-1:0]   node_a;
    logic [bii_pkg::NODE_W-1:0]   node_b;
    logic [bii_pkg::NODE_W-1:0]   node_c;
    logic [bii_pkg::NODE_W-1:0]   node_d;
    logic [bii_pkg::SLOTF_W-1:0]  read_slot;

    modport source (output valid, op, row, node_a, node_b, node_c, node_d, read_slot,
                    input ready);
    modport sink   (input valid, op, row, node_a, node_b, node_c, node_d, read_slot,
                    output ready);
endinterface

interface bii_out_if;
    logic                                valid;
    logic                                ready;
    logic [bii_pkg::PLACED_W-1:0]        placed_a;
    logic [bii_pkg::PLACED_W-1:0]        placed_b;
    logic [bii_pkg::PLACED_W-1:0]        placed_c;
    logic [bii_pkg::PLACED_W-1:0]        placed_d;
    logic signed [bii_pkg::VALUE_W-1:0]  read_value;

    modport source (output valid, placed_a, placed_b, placed_c, placed_d, read_value,
                    input ready);
    modport sink   (input valid, placed_a, placed_b, placed_c, placed_d, read_value,
                    output ready);
endinterface

// File: rtl/bii_ram.sv
module bii_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/bii_ctrl.sv
module bii_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bii_pkg::t_status i_status,
    output bii_pkg::t_cmd    o_cmd
);

    bii_pkg::t_state                r_state, n_state;
    logic [bii_pkg::COL_W-1:0]      r_col, n_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bii_pkg::ST_IDLE;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_col        = r_col;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.col    = r_col;
        case (r_state)
            bii_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_col      = '0;
                    n_state    = bii_pkg::ST_LOOKUP;
                end
            end
            bii_pkg::ST_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state      = bii_pkg::ST_UPDATE;
            end
            bii_pkg::ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_status.is_read ||
                    r_col == bii_pkg::COL_W'(bii_pkg::NUM_COLS - 1)) begin
                    n_state = bii_pkg::ST_DONE;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = bii_pkg::ST_LOOKUP;
                end
            end
            bii_pkg::ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = bii_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bii_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/bii_dp.sv
module bii_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bii_pkg::t_cmd                 i_cmd,
    output bii_pkg::t_status              o_status,
    input  logic [bii_pkg::OP_W-1:0]      i_op,
    input  logic [bii_pkg::ROW_W-1:0]     i_row,
    input  logic [bii_pkg::NODE_W-1:0]    i_node_a,
    input  logic [bii_pkg::NODE_W-1:0]    i_node_b,
    input  logic [bii_pkg::NODE_W-1:0]    i_node_c,
    input  logic [bii_pkg::NODE_W-1:0]    i_node_d,
    input  logic [bii_pkg::SLOTF_W-1:0]   i_read_slot,
    bii_out_if.source                     o_out
);

    // Working copy of the word
    logic [bii_pkg::OP_W-1:0]     r_op;
    logic [bii_pkg::ROW_W-1:0]    r_row;
    logic [bii_pkg::NODE_W-1:0]   r_node [bii_pkg::NUM_COLS];
    logic [bii_pkg::SLOTF_W-1:0]  r_slot;
    logic [bii_pkg::PLACED_W-1:0] r_placed [bii_pkg::NUM_COLS];
    logic [bii_pkg::VALUE_W-1:0]  r_value;

    // Per-node flag: fill count in the RAM is meaningful (else bucket empty)
    logic [bii_pkg::NUM_NODES-1:0] r_cnt_valid;

    // Output register
    logic                         r_out_valid;
    logic [bii_pkg::PLACED_W-1:0] r_o_placed [bii_pkg::NUM_COLS];
    logic [bii_pkg::VALUE_W-1:0]  r_o_value;

    logic [bii_pkg::NODE_W-1:0]     cur_node;
    logic                           node_ok;
    logic [bii_pkg::NODE_IDX_W-1:0] node_idx;
    logic [bii_pkg::CNT_W-1:0]      cnt_rdata;
    logic [bii_pkg::CNT_W-1:0]      cnt;
    logic                           has_room;
    logic                           ins_we;
    logic [bii_pkg::ADDR_W-1:0]     base_addr;
    logic [bii_pkg::ADDR_W-1:0]     data_addr;
    logic [bii_pkg::ROW_W-1:0]      data_rdata;
    logic                           slot_hit;
    logic                           out_free;

    assign cur_node = r_node[i_cmd.col];
    assign node_ok  = 32'(cur_node) < bii_pkg::NUM_NODES;
    assign node_idx = bii_pkg::NODE_IDX_W'(cur_node);
    assign cnt      = r_cnt_valid[node_idx] ? cnt_rdata : '0;
    assign has_room = node_ok && (32'(cnt) < bii_pkg::SLOTS_PER_NODE);
    assign ins_we   = i_cmd.update && (r_op == bii_pkg::OP_INSERT) && has_room;

    assign base_addr = bii_pkg::ADDR_W'(node_idx) *
                       bii_pkg::ADDR_W'(bii_pkg::SLOTS_PER_NODE);
    assign data_addr = (r_op == bii_pkg::OP_READ) ?
                       base_addr + bii_pkg::ADDR_W'(r_slot) :
                       base_addr + bii_pkg::ADDR_W'(cnt);

    // A slot is occupied exactly when it sits below the bucket's fill count
    assign slot_hit = node_ok && (32'(r_slot) < bii_pkg::SLOTS_PER_NODE) &&
                      (32'(r_slot) < 32'(cnt));

    bii_ram #(
        .WIDTH (bii_pkg::CNT_W),
        .DEPTH (bii_pkg::NUM_NODES)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (ins_we),
        .i_re    (i_cmd.lookup),
        .i_addr  (node_idx),
        .i_wdata (cnt + 1'b1),
        .o_rdata (cnt_rdata)
    );

    bii_ram #(
        .WIDTH (bii_pkg::ROW_W),
        .DEPTH (bii_pkg::STORE_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (ins_we),
        .i_re    (i_cmd.lookup),
        .i_addr  (data_addr),
        .i_wdata (r_row),
        .o_rdata (data_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_row     <= i_row;
            r_node[0] <= i_node_a;
            r_node[1] <= i_node_b;
            r_node[2] <= i_node_c;
            r_node[3] <= i_node_d;
            r_slot    <= i_read_slot;
            r_value   <= '0;
            for (int k = 0; k < bii_pkg::NUM_COLS; k++) begin
                r_placed[k] <= '0;
            end
        end else if (i_cmd.update) begin
            if (r_op == bii_pkg::OP_READ) begin
                r_value <= slot_hit ? bii_pkg::VALUE_W'(data_rdata) : bii_pkg::FREE_VALUE;
            end else begin
                r_placed[i_cmd.col] <= has_room ? bii_pkg::PLACED_W'(cnt) :
                                       bii_pkg::PLACED_W'(bii_pkg::SLOTS_PER_NODE);
            end
        end
        if (i_cmd.emit) begin
            r_o_placed <= r_placed;
            r_o_value  <= r_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (ins_we) begin
                r_cnt_valid[node_idx] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign out_free          = !r_out_valid || o_out.ready;
    assign o_status.is_read  = (r_op == bii_pkg::OP_READ);
    assign o_status.out_free = out_free;

    assign o_out.valid      = r_out_valid;
    assign o_out.placed_a   = r_o_placed[0];
    assign o_out.placed_b   = r_o_placed[1];
    assign o_out.placed_c   = r_o_placed[2];
    assign o_out.placed_d   = r_o_placed[3];
    assign o_out.read_value = r_o_value;

endmodule

// File: rtl/bucket_incidence_index_builder.sv
// Channel   Dir  Role    Payload
// i_in      in   sink    op, row, node_a..node_d, read_slot
// o_out     out  source  placed_a..placed_d, read_value
//
// Insert word: per column a fill count read (LOOKUP), then the write back
// (UPDATE), over all four columns; DONE then loads the result register.
// Read word: one LOOKUP and UPDATE on node_a, then DONE. A new word is taken only in IDLE.
// A new word is taken while the result waits at o_out.
// Reset clears per-node count flags at once; no clearing pass over the store.
// A finished result holds in DONE while o_out stalls.
module bucket_incidence_index_builder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bii_in_if.sink    i_in,
    bii_out_if.source o_out
);

    bii_pkg::t_cmd    cmd;
    bii_pkg::t_status status;

    bii_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bii_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_op        (i_in.op),
        .i_row       (i_in.row),
        .i_node_a    (i_in.node_a),
        .i_node_b    (i_in.node_b),
        .i_node_c    (i_in.node_c),
        .i_node_d    (i_in.node_d),
        .i_read_slot (i_in.read_slot),
        .o_out       (o_out)
    );

endmodule

// File: tb/tb_bucket_incidence_index_builder.sv
module tb_bucket_incidence_index_builder;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [bii_pkg::OP_W-1:0]    op;
        logic [bii_pkg::ROW_W-1:0]   row;
        logic [bii_pkg::NODE_W-1:0]  node_a;
        logic [bii_pkg::NODE_W-1:0]  node_b;
        logic [bii_pkg::NODE_W-1:0]  node_c;
        logic [bii_pkg::NODE_W-1:0]  node_d;
        logic [bii_pkg::SLOTF_W-1:0] read_slot;
    } t_word;

    typedef struct packed {
        logic [bii_pkg::PLACED_W-1:0]       placed_a;
        logic [bii_pkg::PLACED_W-1:0]       placed_b;
        logic [bii_pkg::PLACED_W-1:0]       placed_c;
        logic [bii_pkg::PLACED_W-1:0]       placed_d;
        logic signed [bii_pkg::VALUE_W-1:0] read_value;
    } t_result;

    class incidence_scoreboard;
        logic [bii_pkg::VALUE_W-1:0] bucket_mirror [bii_pkg::NUM_NODES][bii_pkg::SLOTS_PER_NODE];
        t_result                     pending_results [$];
        int unsigned                 mismatches;

        function new();
            foreach (bucket_mirror[n, s]) bucket_mirror[n][s] = bii_pkg::FREE_VALUE;
            mismatches = 0;
        endfunction

        // lowest free slot takes the row; a full bucket drops the node
        function logic [bii_pkg::PLACED_W-1:0] place_row(int unsigned node,
                                                         logic [bii_pkg::ROW_W-1:0] row);
            int s;
            if (node >= bii_pkg::NUM_NODES)
                return bii_pkg::PLACED_W'(bii_pkg::SLOTS_PER_NODE);
            for (s = 0; s < bii_pkg::SLOTS_PER_NODE; s++) begin
                if (bucket_mirror[node][s][bii_pkg::VALUE_W-1]) begin
                    bucket_mirror[node][s] = {1'b0, row};
                    return bii_pkg::PLACED_W'(s);
                end
            end
            return bii_pkg::PLACED_W'(bii_pkg::SLOTS_PER_NODE);
        endfunction

        function void note_input(t_word w);
            t_result r;
            r = '0;
            if (w.op == bii_pkg::OP_INSERT) begin
                // columns in order, so repeated nodes see earlier writes
                r.placed_a = place_row(w.node_a, w.row);
                r.placed_b = place_row(w.node_b, w.row);
                r.placed_c = place_row(w.node_c, w.row);
                r.placed_d = place_row(w.node_d, w.row);
            end else begin
                if (w.node_a < bii_pkg::NUM_NODES && w.read_slot < bii_pkg::SLOTS_PER_NODE)
                    r.read_value = bucket_mirror[w.node_a][w.read_slot];
                else
                    r.read_value = bii_pkg::FREE_VALUE;
            end
            pending_results.push_back(r);
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report("result word with nothing expected");
                return;
            end
            want = pending_results.pop_front();
            if (got.placed_a !== want.placed_a)
                report($sformatf("placed_a got %0d want %0d", got.placed_a, want.placed_a));
            if (got.placed_b !== want.placed_b)
                report($sformatf("placed_b got %0d want %0d", got.placed_b, want.placed_b));
            if (got.placed_c !== want.placed_c)
                report($sformatf("placed_c got %0d want %0d", got.placed_c, want.placed_c));
            if (got.placed_d !== want.placed_d)
                report($sformatf("placed_d got %0d want %0d", got.placed_d, want.placed_d));
            if (got.read_value !== want.read_value)
                report($sformatf("read_value got %0d want %0d",
                                 got.read_value, want.read_value));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;

    incidence_scoreboard sb;

    bii_in_if  i_in ();
    bii_out_if o_out ();

    bucket_incidence_index_builder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("bucket_incidence_index_builder test failed");
        $finish;
    end

    always @(negedge i_clk) begin
        o_out.ready <= i_rst_n && ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in.valid && i_in.ready)
                sb.note_input('{i_in.op, i_in.row, i_in.node_a, i_in.node_b,
                                i_in.node_c, i_in.node_d, i_in.read_slot});
            if (o_out.valid && o_out.ready)
                sb.check_result('{o_out.placed_a, o_out.placed_b, o_out.placed_c,
                                  o_out.placed_d, o_out.read_value});
        end
    end

    function automatic t_word mk_word(logic [bii_pkg::OP_W-1:0] op,
                                      logic [bii_pkg::ROW_W-1:0] row,
                                      logic [bii_pkg::NODE_W-1:0] a,
                                      logic [bii_pkg::NODE_W-1:0] b,
                                      logic [bii_pkg::NODE_W-1:0] c,
                                      logic [bii_pkg::NODE_W-1:0] d,
                                      logic [bii_pkg::SLOTF_W-1:0] slot);
        t_word w;
        w = '{op, row, a, b, c, d, slot};
        return w;
    endfunction

    // mostly a small window of nodes so buckets fill up and start dropping
    function automatic logic [bii_pkg::NODE_W-1:0] pick_node(
        logic [bii_pkg::NODE_W-1:0] hot_base);
        if ($urandom_range(99) < 60)
            return hot_base + bii_pkg::NODE_W'($urandom_range(11));
        return bii_pkg::NODE_W'($urandom_range(bii_pkg::NUM_NODES - 1));
    endfunction

    function automatic t_word random_word(logic [bii_pkg::NODE_W-1:0] hot_base);
        t_word w;
        w.op        = ($urandom_range(99) < 70) ? bii_pkg::OP_INSERT : bii_pkg::OP_READ;
        w.row       = bii_pkg::ROW_W'($urandom);
        w.node_a    = pick_node(hot_base);
        w.node_b    = pick_node(hot_base);
        w.node_c    = pick_node(hot_base);
        w.node_d    = pick_node(hot_base);
        w.read_slot = bii_pkg::SLOTF_W'($urandom);
        return w;
    endfunction

    task send_word(t_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            i_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in.valid     <= 1'b1;
        i_in.op        <= w.op;
        i_in.row       <= w.row;
        i_in.node_a    <= w.node_a;
        i_in.node_b    <= w.node_b;
        i_in.node_c    <= w.node_c;
        i_in.node_d    <= w.node_d;
        i_in.read_slot <= w.read_slot;
        do @(posedge i_clk); while (!i_in.ready);
    endtask

    task wait_drained();
        @(negedge i_clk);
        i_in.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        logic [bii_pkg::NODE_W-1:0] hot_base;
        int                         phase;

        sb             = new();
        i_rst_n        = 1'b0;
        i_in.valid     = 1'b0;
        i_in.op        = bii_pkg::OP_INSERT;
        i_in.row       = '0;
        i_in.node_a    = '0;
        i_in.node_b    = '0;
        i_in.node_c    = '0;
        i_in.node_d    = '0;
        i_in.read_slot = '0;
        o_out.ready    = 1'b0;
        src_idle_pct   = 6;
        sink_idle_pct  = 47;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // repeated node in one row, extreme rows and nodes
        send_word(mk_word(bii_pkg::OP_INSERT, 15'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd0));
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h7fff, 8'd255, 8'd255, 8'd255, 8'd255,
                          4'd15));
        send_word(mk_word(bii_pkg::OP_READ, 15'h7fff, 8'd0, 8'd255, 8'd255, 8'd255, 4'd0));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd3));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd0, 8'd0, 8'd0, 8'd0, 4'd4));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd255, 8'd0, 8'd0, 8'd0, 4'd15));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd255, 8'd0, 8'd0, 8'd0, 4'd3));
        // fill bucket 1, then hit it while full
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h5555, 8'd1, 8'd1, 8'd1, 8'd1, 4'd0));
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h2aaa, 8'd1, 8'd1, 8'd1, 8'd1, 4'd0));
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h0f0f, 8'd1, 8'd1, 8'd1, 8'd1, 4'd0));
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h70f0, 8'd1, 8'd1, 8'd1, 8'd1, 4'd0));
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h1234, 8'd1, 8'd2, 8'd1, 8'd3, 4'd0));
        send_word(mk_word(bii_pkg::OP_INSERT, 15'h4321, 8'd2, 8'd1, 8'd3, 8'd1, 4'd0));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd1, 8'd0, 8'd0, 8'd0, 4'd15));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd1, 8'd0, 8'd0, 8'd0, 4'd0));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd2, 8'd0, 8'd0, 8'd0, 4'd1));
        send_word(mk_word(bii_pkg::OP_READ, 15'd0, 8'd200, 8'd0, 8'd0, 8'd0, 4'd7));
        send_word(mk_word(bii_pkg::OP_READ, 15'h7fff, 8'd170, 8'd85, 8'd170, 8'd85, 4'd10));

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct  = 6;
                    sink_idle_pct = 47;
                end
                1: begin
                    src_idle_pct  = 47;
                    sink_idle_pct = 6;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            hot_base = bii_pkg::NODE_W'($urandom);
            repeat (645) send_word(random_word(hot_base));
            // sender holds off until every result of the phase is in
            wait_drained();
        end

        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("bucket_incidence_index_builder test passed");
        end else begin
            $display("bucket_incidence_index_builder test failed");
        end
        $finish;
    end

endmodule
